### rtl/core/lbf_pkg.sv
package lbf_pkg;

    // Default capacity of one line buffer, terminator slot included.
    localparam int LINE_BYTES_DEF = 64;

    typedef logic [7:0] byte_t;

    localparam byte_t CHAR_CR = 8'h0D;
    localparam byte_t CHAR_LF = 8'h0A;

endpackage

### rtl/core/lbf_front.sv
module lbf_front #(
    parameter int LINE_BYTES = lbf_pkg::LINE_BYTES_DEF,
    parameter int IDX_W      = $clog2(LINE_BYTES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  lbf_pkg::byte_t       in_data,
    output logic                 in_ready,
    input  logic                 q_full,
    output logic                 push,
    output logic                 push_bank,
    output logic [IDX_W-1:0]     push_count,
    output logic                 wr_en,
    output logic [IDX_W:0]       wr_addr,
    output lbf_pkg::byte_t       wr_data
);

    logic [IDX_W-1:0] fill_reg;
    logic [IDX_W-1:0] fill_next;
    logic             drop_reg;
    logic             drop_next;
    logic             bank_reg;
    logic             bank_next;
    logic             accept;

    // Every request waits while both line banks hold lines awaiting replay.
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign push_bank  = bank_reg;
    assign push_count = fill_reg;
    assign wr_addr    = {bank_reg, fill_reg};
    assign wr_data    = in_data;

    always_comb
    begin
        fill_next = fill_reg;
        drop_next = drop_reg;
        bank_next = bank_reg;
        push      = 1'b0;
        wr_en     = 1'b0;
        if (accept)
        begin
            if (in_data == lbf_pkg::CHAR_CR)
            begin
                // Carriage returns are discarded.
            end
            else if (in_data == lbf_pkg::CHAR_LF)
            begin
                if (!drop_reg && (fill_reg != '0))
                begin
                    push      = 1'b1;
                    bank_next = !bank_reg;
                end
                fill_next = '0;
                drop_next = 1'b0;
            end
            else if (drop_reg)
            begin
                // Rest of an overlong line is discarded.
            end
            else if (fill_reg == IDX_W'(LINE_BYTES - 1))
            begin
                drop_next = 1'b1;
                fill_next = '0;
            end
            else
            begin
                wr_en     = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            drop_reg <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            drop_reg <= drop_next;
            bank_reg <= bank_next;
        end
    end

endmodule

### rtl/core/lbf_cmd_fifo.sv
module lbf_cmd_fifo #(
    parameter int W = 7
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output logic [W-1:0] head
);

    logic [W-1:0] entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/core/lbf_back.sv
module lbf_back #(
    parameter int LINE_BYTES = lbf_pkg::LINE_BYTES_DEF,
    parameter int IDX_W      = $clog2(LINE_BYTES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  logic             q_bank,
    input  logic [IDX_W-1:0] q_count,
    output logic             q_pop,
    input  logic             wr_en,
    input  logic [IDX_W:0]   wr_addr,
    input  lbf_pkg::byte_t   wr_data,
    output logic             out_valid,
    input  logic             out_ready,
    output lbf_pkg::byte_t   out_data,
    output logic             out_last
);

    localparam int DEPTH = 2 * (1 << IDX_W);

    lbf_pkg::byte_t   mem [DEPTH];
    lbf_pkg::byte_t   rd_data_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    lbf_pkg::byte_t   out_data_reg;
    logic             out_last_reg;
    logic             rd_move;
    logic             issue;
    logic             is_last;

    assign rd_move = rd_valid_reg && (!out_valid_reg || out_ready);
    assign issue   = q_valid && (!rd_valid_reg || rd_move);
    assign is_last = (idx_reg == q_count - 1'b1);
    // The bank is released once its last byte has been read out.
    assign q_pop   = issue && is_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[{q_bank, idx_reg}];
            rd_last_reg <= is_last;
        end
        if (rd_move)
        begin
            out_data_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                rd_valid_reg <= 1'b1;
                idx_reg      <= is_last ? '0 : idx_reg + 1'b1;
            end
            else if (rd_move)
            begin
                rd_valid_reg <= 1'b0;
            end
            if (rd_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### rtl/core/newline_line_framer_unit.sv
// Channel    Direction  Payload                          Accepted when
// s_axis     in         tdata[7:0] in_byte               s_axis_tvalid && s_axis_tready
// m_axis     out        tdata[7:0] line_byte, tlast      m_axis_tvalid && m_axis_tready
//
// A finished line of N bytes is replayed at one byte per cycle while m_axis_tready
// stays high, through the read port of the line memory; its first byte passes a
// registered read stage and then an output register before it is offered.
// The memory holds two line banks, so the input stalls only while two finished
// lines are still waiting for replay. Reset clears only control state; the line
// memory needs no clearing pass, since only written entries are ever read.
module newline_line_framer_unit #(
    parameter int LINE_BYTES = lbf_pkg::LINE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  lbf_pkg::byte_t s_axis_tdata,   // [7:0] in_byte
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output lbf_pkg::byte_t m_axis_tdata,   // [7:0] line_byte
    output logic           m_axis_tlast    // line_last
);

    localparam int IDX_W = $clog2(LINE_BYTES);

    // Handoff between the front end and the replay engine: one request per
    // finished line, carrying its bank and its byte count.
    logic             push;
    logic             push_bank;
    logic [IDX_W-1:0] push_count;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [IDX_W:0]   q_head;
    logic             wr_en;
    logic [IDX_W:0]   wr_addr;
    lbf_pkg::byte_t   wr_data;

    // The front end classifies bytes, tracks fill level and drop mode, and
    // writes data bytes into the bank currently being assembled.
    lbf_front #(
        .LINE_BYTES(LINE_BYTES),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .q_full    (q_full),
        .push      (push),
        .push_bank (push_bank),
        .push_count(push_count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Two-entry queue, matching the two line banks.
    lbf_cmd_fifo #(
        .W(IDX_W + 1)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data({push_bank, push_count}),
        .pop      (q_pop),
        .full     (q_full),
        .not_empty(q_valid),
        .head     (q_head)
    );

    // The replay engine owns the line memory and streams lines out through a
    // registered read stage and an output register.
    lbf_back #(
        .LINE_BYTES(LINE_BYTES),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_bank   (q_head[IDX_W]),
        .q_count  (q_head[IDX_W-1:0]),
        .q_pop    (q_pop),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata),
        .out_last (m_axis_tlast)
    );

endmodule

### rtl/core/lbf_checker.sv
module lbf_checker #(
    parameter int LINE_BYTES = lbf_pkg::LINE_BYTES_DEF
) (
    input logic           clk,
    input logic           rst_n,
    input logic           s_axis_tvalid,
    input logic           s_axis_tready,
    input lbf_pkg::byte_t s_axis_tdata,
    input logic           m_axis_tvalid,
    input logic           m_axis_tready,
    input lbf_pkg::byte_t m_axis_tdata,
    input logic           m_axis_tlast
);

    localparam int RUN_W = $clog2(LINE_BYTES + 1);

    logic [RUN_W-1:0] run_reg;
    logic             seen_lf_reg;
    logic             out_xfer;
    logic             in_xfer;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == lbf_pkg::CHAR_LF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            seen_lf_reg <= 1'b0;
        end
        else
        begin
            if (out_xfer)
            begin
                run_reg <= m_axis_tlast ? '0 : run_reg + 1'b1;
            end
            if (in_xfer)
            begin
                seen_lf_reg <= 1'b1;
            end
        end
    end

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
    else $error("stalled result changed");

    // Line terminators are never part of a replayed line.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata != lbf_pkg::CHAR_CR)
            && (m_axis_tdata != lbf_pkg::CHAR_LF))
    else $error("terminator byte in output line");

    // No line is longer than the buffer minus the terminator slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (run_reg < RUN_W'(LINE_BYTES - 1)))
    else $error("output line too long");

    // No result can be offered before the first line feed has been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> seen_lf_reg)
    else $error("result appeared before any line feed");

    // Reset leaves no result pending.
    assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind newline_line_framer_unit lbf_checker #(
    .LINE_BYTES(LINE_BYTES)
) u_lbf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

### dv/line_framer_checker.sv
module line_framer_checker #(
    parameter int LINE_BYTES = lbf_pkg::LINE_BYTES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    input  logic           s_axis_tready,
    input  lbf_pkg::byte_t s_axis_tdata,    // [7:0] in_byte
    input  logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    input  lbf_pkg::byte_t m_axis_tdata,    // [7:0] line_byte
    input  logic           m_axis_tlast,    // line_last
    output int             errors,
    output int             waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = $clog2(LINE_BYTES);

    typedef struct packed {
        lbf_pkg::byte_t data;
        logic           last;
    } line_beat_t;

    line_beat_t       lines_due[$];
    lbf_pkg::byte_t   held_bytes[LINE_BYTES];
    logic [IDX_W-1:0] held_count;
    logic             discarding;
    line_beat_t       beat;

    // Mirrors the framer for one accepted request and queues the bytes of any
    // line that it completes.
    task automatic absorb_byte(input lbf_pkg::byte_t b);
        line_beat_t due;
        if (b == lbf_pkg::CHAR_CR)
            return;
        if (b == lbf_pkg::CHAR_LF)
        begin
            if (!discarding)
            begin
                for (int i = 0; i < int'(held_count); i++)
                begin
                    due.data = held_bytes[i];
                    due.last = (i + 1 == int'(held_count));
                    lines_due.push_back(due);
                end
            end
            held_count = '0;
            discarding = 1'b0;
            return;
        end
        if (discarding)
            return;
        if (int'(held_count) + 1 >= LINE_BYTES)
        begin
            discarding = 1'b1;
            held_count = '0;
            return;
        end
        held_bytes[held_count] = b;
        held_count = held_count + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_due.delete();
            held_count = '0;
            discarding = 1'b0;
            errors = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (lines_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected line byte: expected none, got %02h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    beat = lines_due.pop_front();
                    if (m_axis_tdata !== beat.data)
                    begin
                        errors++;
                        $display("%0t: line_byte mismatch: expected %02h, got %02h",
                                 $time, beat.data, m_axis_tdata);
                    end
                    if (m_axis_tlast !== beat.last)
                    begin
                        errors++;
                        $display("%0t: line_last mismatch: expected %0b, got %0b",
                                 $time, beat.last, m_axis_tlast);
                    end
                end
            end
        end
        waiting = lines_due.size();
    end

endmodule

### dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // This limit only catches a hang; a normal run ends well before it.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 460;
    localparam int IDLE_PERCENT = 38;

    logic           clk           = 1'b0;
    logic           rst_n         = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    lbf_pkg::byte_t s_axis_tdata  = '0;
    logic           m_axis_tready = 1'b0;
    logic           s_axis_tready;
    logic           m_axis_tvalid;
    lbf_pkg::byte_t m_axis_tdata;
    logic           m_axis_tlast;

    int mismatches;
    int lines_owed;
    int cycles     = 0;
    int bytes_sent = 0;
    // While set, neither side idles, so back-to-back requests and replays
    // run at full rate for a while.
    bit steady     = 1'b0;

    newline_line_framer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    line_framer_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (mismatches),
        .waiting       (lines_owed)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The line consumer stalls at random, except during the steady stretch.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Offers one byte, with random idle cycles ahead of it, and returns at the
    // falling edge after the request was taken. Valid is only lowered by an
    // idle cycle, so a string of bytes goes out back to back when no idle
    // comes up.
    task automatic push_byte(input lbf_pkg::byte_t b);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // One well-formed line of random content. A stray carriage return may
    // fall between bytes, and the line ends in LF or CR LF. Content bytes are
    // fully random, so an embedded line feed now and then splits the line.
    task automatic send_line(input int len, input bit crlf);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_byte(lbf_pkg::CHAR_CR);
            push_byte(8'($urandom_range(0, 255)));
        end
        if (crlf)
            push_byte(lbf_pkg::CHAR_CR);
        push_byte(lbf_pkg::CHAR_LF);
    endtask

    initial
    begin
        lbf_pkg::byte_t directed[$];
        int             pick;
        int             len;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: a lone carriage return, an empty line, a zero byte
        // as data, the extreme byte values, carriage returns inside a line,
        // back-to-back line feeds and a CR LF pair with nothing before it.
        directed = '{lbf_pkg::CHAR_CR, lbf_pkg::CHAR_LF,
                     8'h00, lbf_pkg::CHAR_LF,
                     8'hFF, lbf_pkg::CHAR_CR, 8'h55, 8'hAA, lbf_pkg::CHAR_LF,
                     lbf_pkg::CHAR_LF,
                     lbf_pkg::CHAR_CR, lbf_pkg::CHAR_LF,
                     8'h41, 8'h42, lbf_pkg::CHAR_CR, lbf_pkg::CHAR_CR, 8'h7F, 8'h80,
                     lbf_pkg::CHAR_LF};
        foreach (directed[i])
            push_byte(directed[i]);

        // A line that just fits and so replays the longest run, then one byte
        // more, which overflows and drops the whole line.
        bytes_sent = 0;
        send_line(63, 1'b0);
        send_line(64, 1'b1);

        // Random part: mostly short lines, some near or past the capacity,
        // some empty, plus a share of loose CR, LF and data bytes.
        while (bytes_sent < RANDOM_BYTES)
        begin
            steady = (bytes_sent >= 180 && bytes_sent < 280);
            pick   = $urandom_range(0, 99);
            if (pick < 85)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    len = $urandom_range(61, 66);
                else if (pick < 14)
                    len = 0;
                else
                    len = $urandom_range(1, 12);
                send_line(len, 1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 2))
                        0:       push_byte(lbf_pkg::CHAR_CR);
                        1:       push_byte(lbf_pkg::CHAR_LF);
                        default: push_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
        steady = 1'b0;

        // Close whatever line is still open so that it gets replayed too.
        push_byte(lbf_pkg::CHAR_LF);
        s_axis_tvalid <= 1'b0;

        while (lines_owed != 0)
            @(negedge clk);
        // Every expected byte has been taken; give any spurious output some room to
        // show up.
        repeat (16) @(negedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
